// ===== hdl/rcsa_pkg.sv =====
// shared types and codes for the reference-counted slot id allocator
`default_nettype none
package rcsa_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int TAG_W     = 32;
    localparam int SLOT_W    = 8;
    localparam int COUNT_W   = 16;
    localparam int STATUS_W  = 3;

    localparam logic CMD_USE   = 1'b0;
    localparam logic CMD_UNUSE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DENIED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic              command;
        logic [TAG_W-1:0]  owner_tag;
        logic [SLOT_W-1:0] current_slot;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic                write_slot;
    } rsp_t;

    // token walking the cell row
    typedef struct packed {
        logic valid;
        logic hit;
        rsp_t rsp;
    } tok_t;

endpackage
`default_nettype wire

// ===== hdl/refcounted_slot_id_allocator.sv =====
// top level of the reference-counted slot id allocator
//
// usage:
//   a request beat is taken at a rising edge with start high and busy low;
//   request carries command (use / unuse), owner_tag and current_slot.
//   each request gives exactly one result beat: done is high for one cycle
//   with result (status, slot_out, write_slot) valid in that cycle only.
//   the receiver cannot stall, so the result must be taken when shown.
// flow:
//   requests rejected up front (null owner, slot out of range, unuse of
//   slot 0) answer in the cycle after acceptance and never raise busy.
//   all other requests send a token down the row of SLOTS-1 slot cells,
//   one cell per cycle, and answer once it leaves the last cell; busy is
//   low again in the done cycle; no new request is taken while one is in
//   the row, and the length of the cell row sets how long a request takes.
// reset:
//   every slot is free with count zero; no request is in flight.
`default_nettype none
module refcounted_slot_id_allocator
    import rcsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t request,
    output logic      done,
    output rsp_t      result
);

    localparam int CELLS = SLOTS - 1;

    req_t req_reg;
    logic busy_reg, busy_next;
    logic launch_reg, launch_next;
    logic done_reg, done_next;
    rsp_t result_reg, result_next;

    logic accept;
    logic reject;
    tok_t chain [0:CELLS];

    assign accept = start && !busy_reg;
    assign reject = (request.owner_tag == '0)
                 || ({1'b0, request.current_slot} >= (SLOT_W+1)'(SLOTS))
                 || ((request.command == CMD_UNUSE) && (request.current_slot == '0));

    assign chain[0] = '{valid: launch_reg, hit: 1'b0, rsp: '0};

    genvar g;
    generate
        for (g = 1; g <= CELLS; g++)
        begin : g_cell
            rcsa_cell #(
                .IDX (g)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .req     (req_reg),
                .tok_in  (chain[g-1]),
                .tok_out (chain[g])
            );
        end
    endgenerate

    always_comb
    begin
        busy_next   = busy_reg;
        launch_next = 1'b0;
        done_next   = 1'b0;
        result_next = result_reg;
        if (accept)
        begin
            if (reject)
            begin
                done_next   = 1'b1;
                result_next = '{(request.command == CMD_USE) ? ST_INVALID : ST_NOTFOUND,
                                '0, 1'b0};
            end
            else
            begin
                busy_next   = 1'b1;
                launch_next = 1'b1;
            end
        end
        if (chain[CELLS].valid)
        begin
            busy_next   = 1'b0;
            done_next   = 1'b1;
            result_next = chain[CELLS].hit ? chain[CELLS].rsp : '{ST_FULL, '0, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            launch_reg <= launch_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= request;
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== hdl/rcsa_cell.sv =====
// one slot entry of the allocator row, acting when the token passes
`default_nettype none
module rcsa_cell
    import rcsa_pkg::*;
#(
    parameter int IDX = 1
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t req,
    input  wire tok_t tok_in,
    output tok_t      tok_out
);

    localparam logic [SLOT_W-1:0] IDX_B = SLOT_W'(IDX);

    logic [TAG_W-1:0]   owner_reg, owner_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               self_reg, self_next;
    tok_t               tok_reg, tok_next;

    logic hit_slot;

    assign hit_slot = (req.current_slot == IDX_B);

    always_comb
    begin
        owner_next = owner_reg;
        count_next = count_reg;
        self_next  = self_reg;
        tok_next   = tok_in;
        if (tok_in.valid && !tok_in.hit)
        begin
            if (req.command == CMD_USE)
            begin
                if (req.current_slot != '0)
                begin
                    if (hit_slot)
                    begin
                        tok_next.hit = 1'b1;
                        tok_next.rsp = '{ST_OK, '0, 1'b0};
                        if (owner_reg == req.owner_tag)
                        begin
                            if (count_reg != COUNT_MAX)
                                count_next = count_reg + COUNT_W'(1);
                        end
                        else if (owner_reg == '0)
                        begin
                            owner_next = req.owner_tag;
                            count_next = COUNT_W'(1);
                        end
                        else
                        begin
                            tok_next.rsp.status = ST_DENIED;
                        end
                    end
                end
                else if (owner_reg == '0)
                begin
                    // lowest free slot wins
                    tok_next.hit = 1'b1;
                    tok_next.rsp = '{ST_OK, IDX_B, 1'b1};
                    owner_next   = req.owner_tag;
                    count_next   = COUNT_W'(1);
                    self_next    = 1'b1;
                end
            end
            else if (hit_slot)
            begin
                tok_next.hit = 1'b1;
                if (owner_reg != req.owner_tag)
                begin
                    tok_next.rsp = '{ST_NOTFOUND, '0, 1'b0};
                end
                else if (count_reg > COUNT_W'(1))
                begin
                    tok_next.rsp = '{ST_OK, '0, 1'b0};
                    count_next   = count_reg - COUNT_W'(1);
                end
                else
                begin
                    // last reference
                    tok_next.rsp = '{ST_OK, '0, self_reg};
                    owner_next   = '0;
                    count_next   = '0;
                    self_next    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg     <= '0;
            count_reg     <= '0;
            self_reg      <= 1'b0;
            tok_reg.valid <= 1'b0;
            tok_reg.hit   <= 1'b0;
            tok_reg.rsp   <= '0;
        end
        else
        begin
            owner_reg <= owner_next;
            count_reg <= count_next;
            self_reg  <= self_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

// ===== hdl/rcsa_chk.sv =====
// port checker for the allocator and its bind
`default_nettype none
module rcsa_chk
    import rcsa_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t result
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && busy) |-> $past(start && !busy))
        else $error("result beat while busy");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without a request");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result beat");

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.write_slot) |-> (result.status == ST_OK))
        else $error("slot write on a failed request");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |-> (result.slot_out == '0))
        else $error("slot value on a failed request");

endmodule

bind refcounted_slot_id_allocator rcsa_chk u_rcsa_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire
